/* rtl/imt_pkg.sv */
// ----------------------------------------------------------------------------
// imt_pkg
// Shared widths, constants, microcode and lookup tables of the motion tracker.
// ----------------------------------------------------------------------------
package imt_pkg;

  localparam int ACC_W      = 48;
  localparam int OUT_W      = 48;
  localparam int MS_W       = 16;
  localparam int ACL_W      = 16;
  localparam int HEAD_W     = 13;
  localparam int YAW_W      = 13;
  localparam int THR_W      = 15;
  localparam int DEB_W      = 16;
  localparam int TMR_W      = 17;
  localparam int STR_W      = 7;
  localparam int PC_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int HEAD_FULL  = 5760;
  localparam int HEAD_HALF  = 2880;

  // strength: min(127, (excess/100)*127/20) saturates once excess reaches 2000
  localparam int EXC_BIG    = 2000;
  localparam int EXC_W      = 11;
  localparam int RECIP      = 1311;
  localparam int RECIP_W    = 11;
  localparam int RECIP_SH   = 17;
  localparam int Q_W        = 5;
  localparam logic [STR_W-1:0] STR_MAX = '1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS    = 2'd2;

  typedef enum logic [2:0] {
    MS_AX, MS_AY, MS_AZ, MS_VX, MS_VY, MS_VZ
  } mul_src_e;

  typedef enum logic [2:0] {
    AD_VX, AD_VY, AD_VZ, AD_PX, AD_PY, AD_PZ
  } add_dst_e;

  typedef enum logic [1:0] {
    JC_NEVER, JC_NO_INPUT, JC_OUT_BUSY
  } jmp_cond_e;

  typedef struct packed {
    logic             take_in;
    logic             mul_en;
    mul_src_e         mul_src;
    logic             add_en;
    add_dst_e         add_dst;
    logic             emit;
    jmp_cond_e        jcond;
    logic [PC_W-1:0]  jtarget;
  } cword_t;

  typedef struct packed {
    cword_t cw;
    logic   go;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } seq_stat_t;

  function automatic cword_t ucode(input logic [PC_W-1:0] pc);
    cword_t w;
    w = '{take_in: 1'b0, mul_en: 1'b0, mul_src: MS_AX, add_en: 1'b0, add_dst: AD_VX,
          emit: 1'b0, jcond: JC_NEVER, jtarget: '0};
    unique case (pc)
      3'd0: begin
        w.take_in = 1'b1;
        w.jcond   = JC_NO_INPUT;
        w.jtarget = 3'd0;
      end
      3'd1: begin
        w.mul_en  = 1'b1;
        w.mul_src = MS_AX;
      end
      3'd2: begin
        w.mul_en  = 1'b1;
        w.mul_src = MS_AY;
        w.add_en  = 1'b1;
        w.add_dst = AD_VX;
      end
      3'd3: begin
        w.mul_en  = 1'b1;
        w.mul_src = MS_AZ;
        w.add_en  = 1'b1;
        w.add_dst = AD_VY;
      end
      3'd4: begin
        w.mul_en  = 1'b1;
        w.mul_src = MS_VX;
        w.add_en  = 1'b1;
        w.add_dst = AD_VZ;
      end
      3'd5: begin
        w.mul_en  = 1'b1;
        w.mul_src = MS_VY;
        w.add_en  = 1'b1;
        w.add_dst = AD_PX;
      end
      3'd6: begin
        w.mul_en  = 1'b1;
        w.mul_src = MS_VZ;
        w.add_en  = 1'b1;
        w.add_dst = AD_PY;
      end
      3'd7: begin
        w.add_en  = 1'b1;
        w.add_dst = AD_PZ;
        w.emit    = 1'b1;
        w.jcond   = JC_OUT_BUSY;
        w.jtarget = 3'd7;
      end
      default: begin
        w.jcond = JC_NEVER;
      end
    endcase
    return w;
  endfunction

  // q*127/20 for q below 20
  function automatic logic [STR_W-1:0] str_lut(input logic [Q_W-1:0] q);
    logic [STR_W-1:0] s;
    unique case (q)
      5'd0:    s = 7'd0;
      5'd1:    s = 7'd6;
      5'd2:    s = 7'd12;
      5'd3:    s = 7'd19;
      5'd4:    s = 7'd25;
      5'd5:    s = 7'd31;
      5'd6:    s = 7'd38;
      5'd7:    s = 7'd44;
      5'd8:    s = 7'd50;
      5'd9:    s = 7'd57;
      5'd10:   s = 7'd63;
      5'd11:   s = 7'd69;
      5'd12:   s = 7'd76;
      5'd13:   s = 7'd82;
      5'd14:   s = 7'd88;
      5'd15:   s = 7'd95;
      5'd16:   s = 7'd101;
      5'd17:   s = 7'd107;
      5'd18:   s = 7'd114;
      5'd19:   s = 7'd120;
      default: s = STR_MAX;
    endcase
    return s;
  endfunction

endpackage

/* rtl/imu_motion_tracker_unit.sv */
// ----------------------------------------------------------------------------
// imu_motion_tracker_unit
// Dead reckoning by Euler integration with yaw wrap and a debounced Z hit test.
// ----------------------------------------------------------------------------
// a result is registered in the output in the last step, after its request is accepted
// one request at a time, set by the single multiply/accumulate
//   unit that the control store visits for three velocities and three positions
// a request waits in the last step while the previous result is still stalled
// reset clears velocity, position, hit timer, previous z, registers and the step
// ----------------------------------------------------------------------------
module imu_motion_tracker_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [imt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic        [imt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [imt_pkg::HEAD_W-1:0]      heading_raw_i,
  input  logic signed [imt_pkg::ACL_W-1:0]       accel_x_i,
  input  logic signed [imt_pkg::ACL_W-1:0]       accel_y_i,
  input  logic signed [imt_pkg::ACL_W-1:0]       accel_z_i,
  input  logic        [imt_pkg::MS_W-1:0]        elapsed_ms_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [imt_pkg::YAW_W-1:0]       yaw_o,
  output logic signed [imt_pkg::OUT_W-1:0]       vel_x_o,
  output logic signed [imt_pkg::OUT_W-1:0]       vel_y_o,
  output logic signed [imt_pkg::OUT_W-1:0]       vel_z_o,
  output logic signed [imt_pkg::OUT_W-1:0]       pos_x_o,
  output logic signed [imt_pkg::OUT_W-1:0]       pos_y_o,
  output logic signed [imt_pkg::OUT_W-1:0]       pos_z_o,
  output logic                                   hit_flag_o,
  output logic        [imt_pkg::STR_W-1:0]       hit_strength_o
);
  import imt_pkg::*;

  localparam int YI_W   = HEAD_W + 2;
  localparam int RISE_W = ACL_W + 1;
  localparam int EXS_W  = ACL_W + 2;
  localparam logic signed [YI_W-1:0]  HEAD_FULL_S = YI_W'(HEAD_FULL);
  localparam logic signed [YI_W-1:0]  HEAD_HALF_S = YI_W'(HEAD_HALF);
  localparam logic signed [EXS_W-1:0] EXC_BIG_S   = EXS_W'(EXC_BIG);

  // registers
  logic [HEAD_W-1:0] cfg_off_q;
  logic [THR_W-1:0]  cfg_thr_q;
  logic [DEB_W-1:0]  cfg_deb_q;

  // integration state
  logic signed [ACC_W-1:0] vel_x_q, vel_y_q, vel_z_q;
  logic signed [ACC_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [ACL_W-1:0] prev_z_q;
  logic [TMR_W-1:0]        tmr_q, tmr_d;

  // captured request
  logic signed [ACL_W-1:0] ax_q, ay_q, az_q;
  logic [MS_W-1:0]         ms_q;
  logic signed [YAW_W-1:0] yaw_q;
  logic                    hit_q, big_q;
  logic [EXC_W-1:0]        exc_q;

  logic out_valid_q;

  ctrl_t     ctrl;
  seq_stat_t stat;
  logic      in_acc, out_take, emit_go, add_go, mul_go;

  assign in_stall_o    = !ctrl.cw.take_in;
  assign in_acc        = in_valid_i && ctrl.cw.take_in;
  assign out_take      = out_valid_q && !out_stall_i;
  assign stat.in_valid = in_valid_i;
  assign stat.out_busy = out_valid_q && out_stall_i;
  assign emit_go       = ctrl.go && ctrl.cw.emit;
  assign add_go        = ctrl.go && ctrl.cw.add_en;
  assign mul_go        = ctrl.go && ctrl.cw.mul_en;

  imt_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // datapath operand selection
  logic signed [ACC_W-1:0] mul_a, acc_rd, mac_sum;

  always_comb begin
    unique case (ctrl.cw.mul_src)
      MS_AX:   mul_a = ACC_W'(ax_q);
      MS_AY:   mul_a = ACC_W'(ay_q);
      MS_AZ:   mul_a = ACC_W'(az_q);
      MS_VX:   mul_a = vel_x_q;
      MS_VY:   mul_a = vel_y_q;
      MS_VZ:   mul_a = vel_z_q;
      default: mul_a = '0;
    endcase
    unique case (ctrl.cw.add_dst)
      AD_VX:   acc_rd = vel_x_q;
      AD_VY:   acc_rd = vel_y_q;
      AD_VZ:   acc_rd = vel_z_q;
      AD_PX:   acc_rd = pos_x_q;
      AD_PY:   acc_rd = pos_y_q;
      AD_PZ:   acc_rd = pos_z_q;
      default: acc_rd = '0;
    endcase
  end

  imt_mac u_mac (
    .clk_i    (clk_i),
    .mul_en_i (mul_go),
    .mul_a_i  (mul_a),
    .mul_b_i  (ms_q),
    .acc_i    (acc_rd),
    .sum_o    (mac_sum)
  );

  // yaw wrap
  logic signed [YI_W-1:0] yaw_a, yaw_b, yaw_c, yaw_w;

  always_comb begin
    yaw_a = $signed({2'b00, heading_raw_i}) - $signed({2'b00, cfg_off_q});
    yaw_b = (yaw_a >= HEAD_FULL_S) ? yaw_a - HEAD_FULL_S : yaw_a;
    yaw_c = (yaw_b < 0) ? yaw_b + HEAD_FULL_S : yaw_b;
    yaw_w = (yaw_c > HEAD_HALF_S) ? yaw_c - HEAD_FULL_S : yaw_c;
  end

  // hit timer and z rise
  logic [TMR_W:0]           tmr_sum;
  logic [TMR_W-1:0]         tmr_sat;
  logic                     test;
  logic signed [RISE_W-1:0] rise;
  logic signed [EXS_W-1:0]  excess;

  always_comb begin
    tmr_sum = {1'b0, tmr_q} + (TMR_W+1)'(elapsed_ms_i);
    tmr_sat = tmr_sum[TMR_W] ? '1 : tmr_sum[TMR_W-1:0];
    test    = tmr_sat > TMR_W'(cfg_deb_q);
    tmr_d   = test ? '0 : tmr_sat;
    rise    = RISE_W'(accel_z_i) - RISE_W'(prev_z_q);
    excess  = EXS_W'(rise) - $signed({{(EXS_W-THR_W){1'b0}}, cfg_thr_q});
  end

  // strength from the captured excess
  logic [EXC_W+RECIP_W-1:0] q_prod;
  logic [Q_W-1:0]           q_div;
  logic [STR_W-1:0]         strength;

  always_comb begin
    q_prod = (EXC_W+RECIP_W)'(exc_q) * (EXC_W+RECIP_W)'(RECIP);
    q_div  = q_prod[RECIP_SH +: Q_W];
    if (!hit_q) begin
      strength = '0;
    end else if (big_q) begin
      strength = STR_MAX;
    end else begin
      strength = str_lut(q_div);
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_off_q <= '0;
      cfg_thr_q <= '0;
      cfg_deb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADING_OFFSET: cfg_off_q <= cfg_wdata_i[HEAD_W-1:0];
        CFG_HIT_THRESHOLD:  cfg_thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_DEBOUNCE_MS:    cfg_deb_q <= cfg_wdata_i[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // integration and hit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_x_q  <= '0;
      vel_y_q  <= '0;
      vel_z_q  <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      pos_z_q  <= '0;
      prev_z_q <= '0;
      tmr_q    <= '0;
    end else begin
      if (in_acc) begin
        prev_z_q <= accel_z_i;
        tmr_q    <= tmr_d;
      end
      if (add_go) begin
        unique case (ctrl.cw.add_dst)
          AD_VX:   vel_x_q <= mac_sum;
          AD_VY:   vel_y_q <= mac_sum;
          AD_VZ:   vel_z_q <= mac_sum;
          AD_PX:   pos_x_q <= mac_sum;
          AD_PY:   pos_y_q <= mac_sum;
          AD_PZ:   pos_z_q <= mac_sum;
          default: ;
        endcase
      end
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q  <= accel_x_i;
      ay_q  <= accel_y_i;
      az_q  <= accel_z_i;
      ms_q  <= elapsed_ms_i;
      yaw_q <= yaw_w[YAW_W-1:0];
      hit_q <= test && (excess > 0);
      big_q <= excess >= EXC_BIG_S;
      exc_q <= excess[EXC_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      yaw_o          <= yaw_q;
      vel_x_o        <= vel_x_q[OUT_W-1:0];
      vel_y_o        <= vel_y_q[OUT_W-1:0];
      vel_z_o        <= vel_z_q[OUT_W-1:0];
      pos_x_o        <= pos_x_q[OUT_W-1:0];
      pos_y_o        <= pos_y_q[OUT_W-1:0];
      pos_z_o        <= mac_sum[OUT_W-1:0];
      hit_flag_o     <= hit_q;
      hit_strength_o <= strength;
    end
  end

  assign out_valid_o = out_valid_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled result");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second request taken while one is in progress");

  a_no_strength: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_flag_o) |-> (hit_strength_o == '0))
    else $error("strength without hit");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((yaw_o >= -13'sd2879) && (yaw_o <= 13'sd2880)))
    else $error("yaw outside wrap range");

endmodule

/* rtl/imt_seq.sv */
// ----------------------------------------------------------------------------
// imt_seq
// Step counter and control store; conditional jumps hold a step.
// ----------------------------------------------------------------------------
module imt_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imt_pkg::seq_stat_t stat_i,
  output imt_pkg::ctrl_t     ctrl_o
);
  import imt_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  cword_t          cw;
  logic            jmp;

  always_comb begin
    cw = ucode(pc_q);
    unique case (cw.jcond)
      JC_NEVER:    jmp = 1'b0;
      JC_NO_INPUT: jmp = !stat_i.in_valid;
      JC_OUT_BUSY: jmp = stat_i.out_busy;
      default:     jmp = 1'b0;
    endcase
    pc_d = jmp ? cw.jtarget : pc_q + 1'b1;
  end

  assign ctrl_o.cw = cw;
  assign ctrl_o.go = !jmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/imt_mac.sv */
// ----------------------------------------------------------------------------
// imt_mac
// Registered multiply by the sample period, then saturating accumulate.
// ----------------------------------------------------------------------------
module imt_mac (
  input  logic                              clk_i,
  input  logic                              mul_en_i,
  input  logic signed [imt_pkg::ACC_W-1:0]  mul_a_i,
  input  logic        [imt_pkg::MS_W-1:0]   mul_b_i,
  input  logic signed [imt_pkg::ACC_W-1:0]  acc_i,
  output logic signed [imt_pkg::ACC_W-1:0]  sum_o
);
  import imt_pkg::*;

  localparam int PROD_W = ACC_W + MS_W + 1;
  localparam logic signed [PROD_W-1:0] P_MAX = PROD_W'(ACC_MAX);
  localparam logic signed [PROD_W-1:0] P_MIN = PROD_W'(ACC_MIN);

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  prod_sat;
  logic signed [ACC_W:0]    sum_w;

  assign prod_d = mul_a_i * $signed({1'b0, mul_b_i});

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    priority if (prod_q > P_MAX) begin
      prod_sat = ACC_MAX;
    end else if (prod_q < P_MIN) begin
      prod_sat = ACC_MIN;
    end else begin
      prod_sat = prod_q[ACC_W-1:0];
    end
    sum_w = {acc_i[ACC_W-1], acc_i} + {prod_sat[ACC_W-1], prod_sat};
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sum_o = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_o = sum_w[ACC_W-1:0];
    end
  end

endmodule
